>>> hw/rtl/trsf_pkg.sv
`timescale 1ns / 1ps

package trsf_pkg;

  localparam int HOLD_DEPTH_DEF = 32;

  // bytes of interest
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_SIX   = 8'h36;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  localparam logic [7:0]  SIXEL_PARAM = 8'd4;
  localparam logic [7:0]  ATTR_MAX    = 8'hFF;
  localparam logic [15:0] SIZE_MAX    = 16'hFFFF;

  // result kinds
  localparam logic [1:0] KIND_USER = 2'd0;
  localparam logic [1:0] KIND_ATTR = 2'd1;
  localparam logic [1:0] KIND_SIZE = 2'd2;

  typedef struct packed {
    logic accept;     // input transfer this cycle
    logic fetch;      // read held byte at drain pointer
    logic emit;       // load fetched held byte into output
    logic emit_tail;  // load trailing user byte into output
    logic finish;     // drain done, parser back to idle (or to PH_ESC after an escape)
  } trsf_cmd_t;

  typedef struct packed {
    logic out_free;   // output register can take a result
    logic drain_req;  // current input needs held bytes released
    logic ptr_last;   // drain pointer at last held byte
    logic tail_user;  // a trailing user byte follows the drain
  } trsf_sts_t;

endpackage

>>> hw/rtl/trsf_ctrl.sv
`timescale 1ns / 1ps

module trsf_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  trsf_pkg::trsf_sts_t   sts,
  output trsf_pkg::trsf_cmd_t   cmd
);
  import trsf_pkg::*;

  localparam logic [1:0] ST_RUN   = 2'd0;
  localparam logic [1:0] ST_FETCH = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;
  localparam logic [1:0] ST_TAIL  = 2'd3;

  logic [1:0] state_r, state_nxt;

  assign in_ready = (state_r == ST_RUN) && sts.out_free;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_RUN: begin
        cmd.accept = in_valid && in_ready;
        if (cmd.accept && sts.drain_req) begin
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.ptr_last) begin
            cmd.finish = 1'b1;
            state_nxt  = sts.tail_user ? ST_TAIL : ST_RUN;
          end else begin
            state_nxt = ST_FETCH;
          end
        end
      end
      ST_TAIL: begin
        if (sts.out_free) begin
          cmd.emit_tail = 1'b1;
          state_nxt     = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> hw/rtl/trsf_datapath.sv
`timescale 1ns / 1ps

module trsf_datapath #(
  parameter int HOLD_DEPTH = trsf_pkg::HOLD_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_func,
  input  logic [7:0]           in_rx_byte,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [1:0]           out_kind,
  output logic [7:0]           out_user_byte,
  output logic                 out_sixel_supported,
  output logic [15:0]          out_cell_px_width,
  output logic [15:0]          out_cell_px_height,
  output logic                 out_size_taken,
  output logic                 out_last,
  input  trsf_pkg::trsf_cmd_t  cmd,
  output trsf_pkg::trsf_sts_t  sts
);
  import trsf_pkg::*;

  localparam int AW = $clog2(HOLD_DEPTH);
  localparam int CW = $clog2(HOLD_DEPTH + 1);

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_ESC    = 3'd1;
  localparam logic [2:0] PH_CSI    = 3'd2;
  localparam logic [2:0] PH_ATTR   = 3'd3;
  localparam logic [2:0] PH_SIX    = 3'd4;
  localparam logic [2:0] PH_HEIGHT = 3'd5;
  localparam logic [2:0] PH_WIDTH  = 3'd6;

  logic [7:0] mem [HOLD_DEPTH];
  logic [7:0] rdata_r;

  logic [2:0]    phase_r, phase_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [7:0]    attr_r, attr_nxt;
  logic          have_r, have_nxt;
  logic          seen_r, seen_nxt;
  logic [15:0]   hacc_r, hacc_nxt;
  logic [15:0]   wacc_r, wacc_nxt;
  logic          sixel_r, sixel_nxt;
  logic [15:0]   sw_r, sw_nxt;
  logic [15:0]   sh_r, sh_nxt;

  logic [AW-1:0] ptr_r;
  logic [7:0]    tail_byte_r;
  logic          tail_user_r;
  logic          tail_esc_r;

  logic          out_valid_r;
  logic [1:0]    out_kind_r;
  logic [7:0]    out_byte_r;
  logic          out_taken_r;
  logic          out_last_r;

  logic          step_fail;
  logic          drain_req;
  logic          hold_we;
  logic          res_valid;
  logic [1:0]    res_kind;
  logic          res_taken;
  logic          hold_ok;
  logic          is_digit;
  logic [3:0]    digit;
  logic [11:0]   attr_mul;
  logic [19:0]   hacc_mul;
  logic [19:0]   wacc_mul;
  logic          end_sixel;
  logic          size_ok;
  logic          step_apply;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          out_load;

  assign hold_ok  = count_r < CW'(HOLD_DEPTH);
  assign is_digit = in_rx_byte inside {[CH_0:CH_9]};
  assign digit    = in_rx_byte[3:0];

  // times ten as two shifts, then add the digit
  assign attr_mul = {1'b0, attr_r, 3'b000} + {3'b000, attr_r, 1'b0} + {8'd0, digit};
  assign hacc_mul = {1'b0, hacc_r, 3'b000} + {3'b000, hacc_r, 1'b0} + {16'd0, digit};
  assign wacc_mul = {1'b0, wacc_r, 3'b000} + {3'b000, wacc_r, 1'b0} + {16'd0, digit};

  assign end_sixel = have_r && (attr_r == SIXEL_PARAM);
  assign size_ok   = (hacc_r != 16'd0) && (wacc_r != 16'd0);

  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    attr_nxt  = attr_r;
    have_nxt  = have_r;
    seen_nxt  = seen_r;
    hacc_nxt  = hacc_r;
    wacc_nxt  = wacc_r;
    sixel_nxt = sixel_r;
    sw_nxt    = sw_r;
    sh_nxt    = sh_r;
    hold_we   = 1'b0;
    res_valid = 1'b0;
    res_kind  = KIND_USER;
    res_taken = 1'b0;
    step_fail = 1'b0;
    case (phase_r)
      PH_ESC: begin
        if (in_rx_byte == CH_LBRK && hold_ok) begin
          hold_we   = 1'b1;
          phase_nxt = PH_CSI;
        end else begin
          step_fail = 1'b1;
        end
      end
      PH_CSI: begin
        if (in_rx_byte == CH_QMARK && hold_ok) begin
          hold_we   = 1'b1;
          phase_nxt = PH_ATTR;
          attr_nxt  = 8'd0;
          have_nxt  = 1'b0;
          seen_nxt  = 1'b0;
        end else if (in_rx_byte == CH_SIX && hold_ok) begin
          hold_we   = 1'b1;
          phase_nxt = PH_SIX;
        end else begin
          step_fail = 1'b1;
        end
      end
      PH_ATTR: begin
        if (is_digit) begin
          if (hold_ok) begin
            hold_we  = 1'b1;
            attr_nxt = (attr_mul > {4'd0, ATTR_MAX}) ? ATTR_MAX : attr_mul[7:0];
            have_nxt = 1'b1;
          end else begin
            step_fail = 1'b1;
          end
        end else if (in_rx_byte == CH_SEMI) begin
          if (hold_ok) begin
            hold_we  = 1'b1;
            seen_nxt = seen_r | end_sixel;
            attr_nxt = 8'd0;
            have_nxt = 1'b0;
          end else begin
            step_fail = 1'b1;
          end
        end else if (in_rx_byte == CH_C) begin
          seen_nxt  = seen_r | end_sixel;
          attr_nxt  = 8'd0;
          have_nxt  = 1'b0;
          sixel_nxt = seen_r | end_sixel;
          count_nxt = '0;
          phase_nxt = PH_IDLE;
          res_valid = 1'b1;
          res_kind  = KIND_ATTR;
        end else begin
          step_fail = 1'b1;
        end
      end
      PH_SIX: begin
        if (in_rx_byte == CH_SEMI && hold_ok) begin
          hold_we   = 1'b1;
          phase_nxt = PH_HEIGHT;
          hacc_nxt  = 16'd0;
          wacc_nxt  = 16'd0;
        end else begin
          step_fail = 1'b1;
        end
      end
      PH_HEIGHT, PH_WIDTH: begin
        if (is_digit) begin
          if (hold_ok) begin
            hold_we = 1'b1;
            if (phase_r == PH_HEIGHT) begin
              hacc_nxt = (hacc_mul > {4'd0, SIZE_MAX}) ? SIZE_MAX : hacc_mul[15:0];
            end else begin
              wacc_nxt = (wacc_mul > {4'd0, SIZE_MAX}) ? SIZE_MAX : wacc_mul[15:0];
            end
          end else begin
            step_fail = 1'b1;
          end
        end else if (in_rx_byte == CH_SEMI && phase_r == PH_HEIGHT) begin
          if (hold_ok) begin
            hold_we   = 1'b1;
            phase_nxt = PH_WIDTH;
          end else begin
            step_fail = 1'b1;
          end
        end else if (in_rx_byte == CH_T) begin
          if (size_ok) begin
            sw_nxt = wacc_r;
            sh_nxt = hacc_r;
          end
          count_nxt = '0;
          phase_nxt = PH_IDLE;
          res_valid = 1'b1;
          res_kind  = KIND_SIZE;
          res_taken = size_ok;
        end else begin
          step_fail = 1'b1;
        end
      end
      default: begin
        // idle, and any code with no meaning
        phase_nxt = PH_IDLE;
        count_nxt = '0;
        if (in_rx_byte == CH_ESC) begin
          hold_we   = 1'b1;
          count_nxt = CW'(1);
          phase_nxt = PH_ESC;
        end else begin
          res_valid = 1'b1;
        end
      end
    endcase
    if (hold_we && phase_r != PH_IDLE) begin
      count_nxt = count_r + CW'(1);
    end
    if (in_func) begin
      // flush: nothing held means nothing to release
      phase_nxt = PH_IDLE;
      count_nxt = count_r;
      attr_nxt  = attr_r;
      have_nxt  = have_r;
      seen_nxt  = seen_r;
      hacc_nxt  = hacc_r;
      wacc_nxt  = wacc_r;
      sixel_nxt = sixel_r;
      sw_nxt    = sw_r;
      sh_nxt    = sh_r;
      hold_we   = 1'b0;
      res_valid = 1'b0;
    end
  end

  assign drain_req  = in_func ? (count_r != '0) : step_fail;
  assign step_apply = cmd.accept && !drain_req;

  assign sts.out_free  = !out_valid_r || out_ready;
  assign sts.drain_req = drain_req;
  assign sts.ptr_last  = CW'(ptr_r) == (count_r - CW'(1));
  assign sts.tail_user = tail_user_r;

  // held byte store; entry zero takes the escape that restarts after a drain
  assign mem_we    = (step_apply && hold_we) || (cmd.finish && tail_esc_r);
  assign mem_waddr = cmd.finish ? '0 : count_r[AW-1:0];
  assign mem_wdata = cmd.finish ? CH_ESC : in_rx_byte;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.fetch) begin
      rdata_r <= mem[ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      count_r     <= '0;
      attr_r      <= 8'd0;
      have_r      <= 1'b0;
      seen_r      <= 1'b0;
      hacc_r      <= 16'd0;
      wacc_r      <= 16'd0;
      sixel_r     <= 1'b0;
      sw_r        <= 16'd0;
      sh_r        <= 16'd0;
      tail_user_r <= 1'b0;
      tail_esc_r  <= 1'b0;
    end else begin
      if (step_apply) begin
        phase_r <= phase_nxt;
        count_r <= count_nxt;
        attr_r  <= attr_nxt;
        have_r  <= have_nxt;
        seen_r  <= seen_nxt;
        hacc_r  <= hacc_nxt;
        wacc_r  <= wacc_nxt;
        sixel_r <= sixel_nxt;
        sw_r    <= sw_nxt;
        sh_r    <= sh_nxt;
      end
      if (cmd.accept && drain_req) begin
        tail_user_r <= !in_func && (in_rx_byte != CH_ESC);
        tail_esc_r  <= !in_func && (in_rx_byte == CH_ESC);
      end
      if (cmd.finish) begin
        phase_r <= tail_esc_r ? PH_ESC : PH_IDLE;
        count_r <= tail_esc_r ? CW'(1) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && drain_req) begin
      ptr_r       <= '0;
      tail_byte_r <= in_rx_byte;
    end else if (cmd.emit) begin
      ptr_r <= ptr_r + AW'(1);
    end
  end

  assign out_load = (step_apply && res_valid) || cmd.emit || cmd.emit_tail;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind_r  <= KIND_USER;
      out_byte_r  <= rdata_r;
      out_taken_r <= 1'b0;
      out_last_r  <= sts.ptr_last && !tail_user_r;
    end else if (cmd.emit_tail) begin
      out_kind_r  <= KIND_USER;
      out_byte_r  <= tail_byte_r;
      out_taken_r <= 1'b0;
      out_last_r  <= 1'b1;
    end else if (step_apply && res_valid) begin
      out_kind_r  <= res_kind;
      out_byte_r  <= (res_kind == KIND_USER) ? in_rx_byte : 8'd0;
      out_taken_r <= res_taken;
      out_last_r  <= 1'b1;
    end
  end

  // stored values only change on a transfer that loads a fresh result
  assign out_valid           = out_valid_r;
  assign out_kind            = out_kind_r;
  assign out_user_byte       = out_byte_r;
  assign out_sixel_supported = sixel_r;
  assign out_cell_px_width   = sw_r;
  assign out_cell_px_height  = sh_r;
  assign out_size_taken      = out_taken_r;
  assign out_last            = out_last_r;

endmodule

>>> hw/rtl/terminal_reply_sequence_filter.sv
`timescale 1ns / 1ps
// channel  | handshake            | payload
// ---------+----------------------+---------------------------------------------
// in       | in_valid / in_ready  | in_func, in_rx_byte
// out      | out_valid / out_ready| out_kind, out_user_byte, out_sixel_supported,
//          |                      | out_cell_px_width, out_cell_px_height,
//          |                      | out_size_taken, out_last
//
// one byte per cycle while the output register keeps draining and no release is in progress
// a failed match or flush releases the held bytes one at a time, each by a held byte
// store read and then an output load, followed by a trailing user byte if there is one
// no input transfer is taken while a release is in progress
// synchronous active-low reset returns the parser to idle with nothing held
// a stalled output holds its result; input waits until the output register frees

module terminal_reply_sequence_filter #(
  parameter int HOLD_DEPTH = trsf_pkg::HOLD_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_user_byte,
  output logic        out_sixel_supported,
  output logic [15:0] out_cell_px_width,
  output logic [15:0] out_cell_px_height,
  output logic        out_size_taken,
  output logic        out_last
);
  import trsf_pkg::*;

  trsf_cmd_t cmd;
  trsf_sts_t sts;

  trsf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  trsf_datapath #(
    .HOLD_DEPTH (HOLD_DEPTH)
  ) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_func             (in_func),
    .in_rx_byte          (in_rx_byte),
    .out_ready           (out_ready),
    .out_valid           (out_valid),
    .out_kind            (out_kind),
    .out_user_byte       (out_user_byte),
    .out_sixel_supported (out_sixel_supported),
    .out_cell_px_width   (out_cell_px_width),
    .out_cell_px_height  (out_cell_px_height),
    .out_size_taken      (out_size_taken),
    .out_last            (out_last),
    .cmd                 (cmd),
    .sts                 (sts)
  );

endmodule
